// ----- design/pose_2d_frame_transform_defines.svh -----
// Assertion macros for the pose frame transform block
`ifndef POSE_2D_FRAME_TRANSFORM_DEFINES_SVH
`define POSE_2D_FRAME_TRANSFORM_DEFINES_SVH

// Antecedent implies consequent in the same cycle
`define POSE2D_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pose transform check failed");

// Condition never holds
`define POSE2D_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("pose transform check failed");

`endif

// ----- design/pose2d_pkg.sv -----
// Types, constants and angle table for the pose frame transform
`default_nettype none

package pose2d_pkg;

  localparam int ROT_STAGES   = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NUM_CELLS    = (ROT_STAGES < ATAN_ENTRIES) ? ROT_STAGES : ATAN_ENTRIES;
  localparam int IDX_W        = $clog2(ATAN_ENTRIES);
  localparam int LATENCY      = NUM_CELLS + 4;

  localparam int POS_W  = 32;
  localparam int DIFF_W = POS_W + 1;
  localparam int HEAD_W = 16;
  localparam int ANG_W  = 34;
  localparam int CS_W   = 34;

  localparam logic FUNC_COMPOSE = 1'b0;
  localparam logic FUNC_INVERSE = 1'b1;

  localparam logic signed [CS_W-1:0]  CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 34'sh040000000;
  localparam logic signed [ANG_W-1:0] ANG_HALF    = 34'sh080000000;

  typedef struct packed {
    logic                     func;
    logic signed [POS_W-1:0]  pose_x;
    logic signed [POS_W-1:0]  pose_y;
    logic signed [HEAD_W-1:0] pose_heading;
    logic signed [POS_W-1:0]  frame_x;
    logic signed [POS_W-1:0]  frame_y;
    logic signed [HEAD_W-1:0] frame_heading;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [HEAD_W-1:0] out_heading;
    logic                     saturated;
  } out_item_t;

  // Rotator state handed from cell to cell
  typedef struct packed {
    logic signed [CS_W-1:0]  x;
    logic signed [CS_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
    logic                    flip;
  } cordic_t;

  // Operands riding alongside the rotator
  typedef struct packed {
    logic                     func;
    logic signed [DIFF_W-1:0] op_a;
    logic signed [DIFF_W-1:0] op_b;
    logic signed [POS_W-1:0]  off_x;
    logic signed [POS_W-1:0]  off_y;
    logic signed [HEAD_W-1:0] heading;
  } carry_t;

  function automatic logic signed [ANG_W-1:0] atan_at(input logic [IDX_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 34'sh020000000;
      5'd1:    v = 34'sh012E4051E;
      5'd2:    v = 34'sh009FB385B;
      5'd3:    v = 34'sh0051111D4;
      5'd4:    v = 34'sh0028B0D43;
      5'd5:    v = 34'sh00145D7E1;
      5'd6:    v = 34'sh000A2F61E;
      5'd7:    v = 34'sh000517C55;
      5'd8:    v = 34'sh00028BE53;
      5'd9:    v = 34'sh000145F2F;
      5'd10:   v = 34'sh0000A2F98;
      5'd11:   v = 34'sh0000517CC;
      5'd12:   v = 34'sh000028BE6;
      5'd13:   v = 34'sh0000145F3;
      5'd14:   v = 34'sh00000A2FA;
      5'd15:   v = 34'sh00000517D;
      5'd16:   v = 34'sh0000028BE;
      5'd17:   v = 34'sh00000145F;
      5'd18:   v = 34'sh000000A30;
      5'd19:   v = 34'sh000000518;
      5'd20:   v = 34'sh00000028C;
      5'd21:   v = 34'sh000000146;
      5'd22:   v = 34'sh0000000A3;
      5'd23:   v = 34'sh000000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- design/pose2d_cordic_cell.sv -----
// One CORDIC rotation cell with its registered operand carry
`default_nettype none

module pose2d_cordic_cell
  import pose2d_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IDX_W-1:0] stage_idx,
  input  wire logic             in_valid,
  input  wire cordic_t          in_cor,
  input  wire carry_t           in_car,
  output logic                  out_valid,
  output cordic_t               out_cor,
  output carry_t                out_car
);

  logic                    valid_r;
  cordic_t                 cor_r, cor_nxt;
  carry_t                  car_r;
  logic signed [CS_W-1:0]  xs, ys;
  logic signed [ANG_W-1:0] ang;

  assign xs  = in_cor.x >>> stage_idx;
  assign ys  = in_cor.y >>> stage_idx;
  assign ang = atan_at(stage_idx);

  always_comb begin
    cor_nxt      = in_cor;
    if (!in_cor.z[ANG_W-1]) begin
      cor_nxt.x = in_cor.x - ys;
      cor_nxt.y = in_cor.y + xs;
      cor_nxt.z = in_cor.z - ang;
    end else begin
      cor_nxt.x = in_cor.x + ys;
      cor_nxt.y = in_cor.y - xs;
      cor_nxt.z = in_cor.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    cor_r <= cor_nxt;
    car_r <= in_car;
  end

  assign out_valid = valid_r;
  assign out_cor   = cor_r;
  assign out_car   = car_r;

endmodule

`default_nettype wire

// ----- design/pose2d_rotate.sv -----
// Sign fix, 2x2 rotation, rounding, offset add and clipping
`default_nettype none

module pose2d_rotate
  import pose2d_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire cordic_t in_cor,
  input  wire carry_t  in_car,
  output logic         out_valid,
  output out_item_t    out_data
);

  localparam int PROD_W = DIFF_W + CS_W;
  localparam int TERM_W = PROD_W - 14;
  localparam int SUM_W  = TERM_W + 1;
  localparam int RND_W  = SUM_W - 16;
  localparam int FIN_W  = RND_W + 1;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);
  localparam logic signed [FIN_W-1:0] POS_MAX    = FIN_W'(64'sd2147483647);
  localparam logic signed [FIN_W-1:0] POS_MIN    = FIN_W'(-64'sd2147483648);

  // stage 1: coefficients
  logic                     v1_r, v2_r, v3_r, v4_r;
  logic signed [CS_W-1:0]   c_v, s_v;
  logic signed [CS_W-1:0]   k1_r, k2_r, k3_r, k4_r;
  logic signed [DIFF_W-1:0] a1_r, b1_r;
  logic signed [POS_W-1:0]  ox1_r, oy1_r, ox2_r, oy2_r, ox3_r, oy3_r;
  logic signed [HEAD_W-1:0] h1_r, h2_r, h3_r;

  assign c_v = in_cor.flip ? -in_cor.x : in_cor.x;
  assign s_v = in_cor.flip ? -in_cor.y : in_cor.y;

  // stage 2: products
  logic signed [PROD_W-1:0] p1, p2, p3, p4;
  logic signed [TERM_W-1:0] t1_r, t2_r, t3_r, t4_r;

  assign p1 = a1_r * k1_r;
  assign p2 = b1_r * k2_r;
  assign p3 = a1_r * k3_r;
  assign p4 = b1_r * k4_r;

  // stage 3: sum and round
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic signed [RND_W-1:0] rx_r, ry_r;

  assign sum_x = SUM_W'(t1_r) + SUM_W'(t2_r) + ROUND_HALF;
  assign sum_y = SUM_W'(t3_r) + SUM_W'(t4_r) + ROUND_HALF;

  // stage 4: offset and clip
  logic signed [FIN_W-1:0] fx, fy;
  logic                    hi_x, lo_x, hi_y, lo_y;
  out_item_t               out_r, out_nxt;

  assign fx   = FIN_W'(rx_r) + FIN_W'(ox3_r);
  assign fy   = FIN_W'(ry_r) + FIN_W'(oy3_r);
  assign hi_x = fx > POS_MAX;
  assign lo_x = fx < POS_MIN;
  assign hi_y = fy > POS_MAX;
  assign lo_y = fy < POS_MIN;

  always_comb begin
    out_nxt.out_x       = hi_x ? POS_MAX[POS_W-1:0] : (lo_x ? POS_MIN[POS_W-1:0] : fx[POS_W-1:0]);
    out_nxt.out_y       = hi_y ? POS_MAX[POS_W-1:0] : (lo_y ? POS_MIN[POS_W-1:0] : fy[POS_W-1:0]);
    out_nxt.out_heading = h3_r;
    out_nxt.saturated   = hi_x | lo_x | hi_y | lo_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    k1_r  <= c_v;
    k2_r  <= (in_car.func == FUNC_INVERSE) ? s_v : -s_v;
    k3_r  <= (in_car.func == FUNC_INVERSE) ? -s_v : s_v;
    k4_r  <= c_v;
    a1_r  <= in_car.op_a;
    b1_r  <= in_car.op_b;
    ox1_r <= in_car.off_x;
    oy1_r <= in_car.off_y;
    h1_r  <= in_car.heading;

    t1_r  <= p1[PROD_W-1:14];
    t2_r  <= p2[PROD_W-1:14];
    t3_r  <= p3[PROD_W-1:14];
    t4_r  <= p4[PROD_W-1:14];
    ox2_r <= ox1_r;
    oy2_r <= oy1_r;
    h2_r  <= h1_r;

    rx_r  <= sum_x[SUM_W-1:16];
    ry_r  <= sum_y[SUM_W-1:16];
    ox3_r <= ox2_r;
    oy3_r <= oy2_r;
    h3_r  <= h2_r;

    out_r <= out_nxt;
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- design/pose_2d_frame_transform.sv -----
// SE(2) pose composition / inverse: CORDIC cell chain, rotator and clip stages
// Accept to out_valid: CORDIC cell registers, then coefficient, product, round, clip.
// Throughput: one pose per cycle; set by the CORDIC cell chain, one cell per stage.
// busy stays low; every result shows for one cycle, the receiver cannot stall.
// Reset (rst_n, synchronous) empties the pipeline; no beat is in flight afterward.
`default_nettype none
`include "pose_2d_frame_transform_defines.svh"

module pose_2d_frame_transform
  import pose2d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  output out_item_t      out_data
);

  logic                    accept;
  logic signed [ANG_W-1:0] z_raw;
  cordic_t                 cor_in;
  carry_t                  car_in;

  logic                    vld_chain [0:NUM_CELLS];
  cordic_t                 cor_chain [0:NUM_CELLS];
  carry_t                  car_chain [0:NUM_CELLS];

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign z_raw  = {{(ANG_W-HEAD_W-16){in_data.frame_heading[HEAD_W-1]}},
                   in_data.frame_heading, 16'b0};

  // half-turn fold into [-quarter, quarter]
  always_comb begin
    cor_in.x    = CORDIC_GAIN;
    cor_in.y    = '0;
    cor_in.z    = z_raw;
    cor_in.flip = 1'b0;
    if (z_raw > ANG_QUARTER) begin
      cor_in.z    = z_raw - ANG_HALF;
      cor_in.flip = 1'b1;
    end else if (z_raw < -ANG_QUARTER) begin
      cor_in.z    = z_raw + ANG_HALF;
      cor_in.flip = 1'b1;
    end
  end

  always_comb begin
    car_in.func = in_data.func;
    if (in_data.func == FUNC_INVERSE) begin
      car_in.op_a    = DIFF_W'(in_data.pose_x) - DIFF_W'(in_data.frame_x);
      car_in.op_b    = DIFF_W'(in_data.pose_y) - DIFF_W'(in_data.frame_y);
      car_in.off_x   = '0;
      car_in.off_y   = '0;
      car_in.heading = in_data.pose_heading - in_data.frame_heading;
    end else begin
      car_in.op_a    = DIFF_W'(in_data.pose_x);
      car_in.op_b    = DIFF_W'(in_data.pose_y);
      car_in.off_x   = in_data.frame_x;
      car_in.off_y   = in_data.frame_y;
      car_in.heading = in_data.pose_heading + in_data.frame_heading;
    end
  end

  assign vld_chain[0] = accept;
  assign cor_chain[0] = cor_in;
  assign car_chain[0] = car_in;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    pose2d_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (IDX_W'(i)),
      .in_valid  (vld_chain[i]),
      .in_cor    (cor_chain[i]),
      .in_car    (car_chain[i]),
      .out_valid (vld_chain[i+1]),
      .out_cor   (cor_chain[i+1]),
      .out_car   (car_chain[i+1])
    );
  end

  pose2d_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_chain[NUM_CELLS]),
    .in_cor    (cor_chain[NUM_CELLS]),
    .in_car    (car_chain[NUM_CELLS]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `POSE2D_ASSERT_IMPLIES(a_out_has_source, out_valid, $past(start, LATENCY))
  `POSE2D_ASSERT_IMPLIES(a_heading_path, out_valid && $past(in_data.func, LATENCY), out_data.out_heading == $past(in_data.pose_heading - in_data.frame_heading, LATENCY))
  `POSE2D_ASSERT_NEVER(a_sat_needs_clip, out_valid && out_data.saturated && out_data.out_x != 32'sh7fffffff && out_data.out_x != 32'sh80000000 && out_data.out_y != 32'sh7fffffff && out_data.out_y != 32'sh80000000)

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for pose_2d_frame_transform: pose composition and inverse
`timescale 1ns / 1ps

module testbench
  import pose2d_pkg::*;
();

  localparam int RANDOM_POSES = 1650;
  localparam longint ROT_GAIN = 64'sd652032874;
  localparam longint QUARTER_TURN = 64'sd1073741824;
  localparam longint HALF_TURN = 64'sd2147483648;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;

  in_item_t pose_jobs[$];
  out_item_t expected_poses[$];
  out_item_t want;
  int idle_left = 0;
  bit no_idle_run = 1'b0;
  int mismatch_count = 0;

  longint atan_step [0:23] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  pose_2d_frame_transform DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always #1 clk = ~clk;

  // Q2.30 cosine and sine of a binary-angle heading
  function automatic void frame_cos_sin(input logic signed [15:0] hd,
                                        output longint c, output longint s);
    longint ang;
    longint cx;
    longint sy;
    longint nx;
    bit flip;
    int i;
    ang = longint'($signed(hd)) * 65536;
    cx = ROT_GAIN;
    sy = 0;
    flip = 1'b0;
    if (ang > QUARTER_TURN) begin
      ang = ang - HALF_TURN;
      flip = 1'b1;
    end else if (ang < -QUARTER_TURN) begin
      ang = ang + HALF_TURN;
      flip = 1'b1;
    end
    for (i = 0; i < ROT_STAGES && i < 24; i++) begin
      if (ang >= 0) begin
        nx = cx - (sy >>> i);
        sy = sy + (cx >>> i);
        ang = ang - atan_step[i];
      end else begin
        nx = cx + (sy >>> i);
        sy = sy - (cx >>> i);
        ang = ang + atan_step[i];
      end
      cx = nx;
    end
    c = flip ? -cx : cx;
    s = flip ? -sy : sy;
  endfunction

  function automatic longint rotate_sum(input longint a, input longint ca,
                                        input longint b, input longint cb);
    return (((a * ca) >>> 14) + ((b * cb) >>> 14) + 64'sd32768) >>> 16;
  endfunction

  function automatic out_item_t transform_pose(input in_item_t p);
    longint c, s, px, py, fx, fy, tx, ty, rx, ry, hd;
    out_item_t r;
    frame_cos_sin(p.frame_heading, c, s);
    px = $signed(p.pose_x);
    py = $signed(p.pose_y);
    fx = $signed(p.frame_x);
    fy = $signed(p.frame_y);
    if (p.func == FUNC_COMPOSE) begin
      rx = rotate_sum(px, c, py, -s) + fx;
      ry = rotate_sum(px, s, py, c) + fy;
      hd = longint'($signed(p.pose_heading)) + longint'($signed(p.frame_heading));
    end else begin
      tx = px - fx;
      ty = py - fy;
      rx = rotate_sum(tx, c, ty, s);
      ry = rotate_sum(tx, -s, ty, c);
      hd = longint'($signed(p.pose_heading)) - longint'($signed(p.frame_heading));
    end
    r.saturated = 1'b0;
    if (rx > POS_MAX) begin
      rx = POS_MAX;
      r.saturated = 1'b1;
    end else if (rx < POS_MIN) begin
      rx = POS_MIN;
      r.saturated = 1'b1;
    end
    if (ry > POS_MAX) begin
      ry = POS_MAX;
      r.saturated = 1'b1;
    end else if (ry < POS_MIN) begin
      ry = POS_MIN;
      r.saturated = 1'b1;
    end
    r.out_x = rx[31:0];
    r.out_y = ry[31:0];
    r.out_heading = hd[15:0];
    return r;
  endfunction

  task automatic queue_pose(input logic f,
                            input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [15:0] ph,
                            input logic signed [31:0] fx, input logic signed [31:0] fy,
                            input logic signed [15:0] fh);
    in_item_t p;
    p.func = f;
    p.pose_x = px;
    p.pose_y = py;
    p.pose_heading = ph;
    p.frame_x = fx;
    p.frame_y = fy;
    p.frame_heading = fh;
    pose_jobs.push_back(p);
  endtask

  // full range, small magnitude, or an edge value
  function automatic logic [31:0] pick_position(input int mode);
    logic [31:0] v;
    if (mode < 4) begin
      v = $urandom;
    end else if (mode < 8) begin
      v = int'($urandom) >>> $urandom_range(7, 20);
    end else begin
      case ($urandom_range(0, 5))
        0: v = 32'h7FFFFFFF;
        1: v = 32'h80000000;
        2: v = 32'h00000000;
        3: v = 32'hFFFFFFFF;
        4: v = 32'h00000001;
        default: v = 32'h00010000;
      endcase
    end
    return v;
  endfunction

  function automatic logic [15:0] pick_heading();
    logic [15:0] v;
    if ($urandom_range(0, 7) != 0) begin
      v = 16'($urandom);
    end else begin
      case ($urandom_range(0, 7))
        0: v = 16'sd16384;
        1: v = 16'sd16385;
        2: v = -16'sd16384;
        3: v = -16'sd16385;
        4: v = 16'h8000;
        5: v = 16'h7FFF;
        6: v = 16'h0000;
        default: v = 16'sd8192;
      endcase
    end
    return v;
  endfunction

  initial begin
    int n;
    int mode;
    queue_pose(FUNC_COMPOSE, 0, 0, 0, 0, 0, 0);
    queue_pose(FUNC_COMPOSE, 32'sh10000, 0, 0, 0, 0, 16'sd16384);
    queue_pose(FUNC_INVERSE, 32'sh10000, 0, 0, 0, 0, 16'sd16384);
    queue_pose(FUNC_COMPOSE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sh7FFF,
               32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
    queue_pose(FUNC_COMPOSE, 32'sh80000000, 32'sh80000000, 16'sh8000,
               32'sh80000000, 32'sh80000000, 0);
    queue_pose(FUNC_INVERSE, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0,
               32'sh80000000, 32'sh80000000, 0);
    queue_pose(FUNC_INVERSE, 32'sh80000000, 32'sh80000000, 0,
               32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
    queue_pose(FUNC_COMPOSE, 32'sh123456, -32'sh654321, 16'sd100, 32'sh1000, 0, 16'sd16385);
    queue_pose(FUNC_INVERSE, 32'sh123456, -32'sh654321, 16'sd100, 0, 32'sh1000, -16'sd16384);
    queue_pose(FUNC_COMPOSE, -32'sh40000, 32'sh30000, 0, 0, 0, -16'sd16385);
    queue_pose(FUNC_INVERSE, -32'sh40000, 32'sh30000, 0, 32'sh5, 32'sh7, 16'sh8000);
    queue_pose(FUNC_COMPOSE, 32'sh50000, 32'sh50000, 0, 0, 0, 16'sh7FFF);
    queue_pose(FUNC_COMPOSE, 0, 0, 16'sh7FFF, 0, 0, 16'sd1);
    queue_pose(FUNC_INVERSE, 0, 0, 16'sh8000, 0, 0, 16'sd1);
    queue_pose(FUNC_COMPOSE, 0, 0, 16'sh8000, 0, 0, 16'sh8000);
    queue_pose(FUNC_INVERSE, -32'sd1, -32'sd1, 0, 0, 0, 0);
    queue_pose(FUNC_COMPOSE, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 16'sd8192);
    queue_pose(FUNC_INVERSE, 32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh80000000, 32'sh7FFFFFFF,
               16'sd8192);
    for (n = 0; n < RANDOM_POSES; n++) begin
      mode = $urandom_range(0, 9);
      queue_pose(1'($urandom_range(0, 1)), pick_position(mode), pick_position(mode),
                 pick_heading(), pick_position(mode), pick_position(mode), pick_heading());
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (pose_jobs.size() > 0 || start || expected_poses.size() > 0)
      @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // driver: one beat per pending pose, random gap before the next
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else if (!start || !busy) begin
      if (start)
        expected_poses.push_back(transform_pose(in_data));
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pose_jobs.size() > 0) begin
        start <= 1'b1;
        in_data <= pose_jobs.pop_front();
        if ($urandom_range(0, 31) == 0)
          no_idle_run = !no_idle_run;
        idle_left = no_idle_run ? 0 : $urandom_range(0, 6);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_poses.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, got x=%h y=%h heading=%h sat=%b",
                 $time, out_data.out_x, out_data.out_y, out_data.out_heading,
                 out_data.saturated);
      end else begin
        want = expected_poses.pop_front();
        if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
            out_data.out_heading !== want.out_heading ||
            out_data.saturated !== want.saturated) begin
          mismatch_count++;
          $display("%0t: mismatch, expected x=%h y=%h heading=%h sat=%b, got x=%h y=%h %s",
                   $time, want.out_x, want.out_y, want.out_heading, want.saturated,
                   out_data.out_x, out_data.out_y,
                   $sformatf("heading=%h sat=%b", out_data.out_heading,
                             out_data.saturated));
        end
      end
    end
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/pose2d_pkg.sv
design/pose2d_cordic_cell.sv
design/pose2d_rotate.sv
design/pose_2d_frame_transform.sv
test/testbench.sv
